@@ hw/rtl/alt_pkg.sv @@
// Shared types, constants and character helpers for the assembler line tokenizer.
package alt_pkg;

    // Default limits for the top-level parameters.
    localparam int LINE_LIMIT_DEF = 1024;
    localparam int NEST_LIMIT_DEF = 16;
    localparam int ARG_LIMIT_DEF  = 64;

    // Byte codes with a fixed meaning in the line structure.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Position within one source line.
    typedef enum logic [3:0] {
        PH_START,
        PH_LABEL,
        PH_LDIGIT,
        PH_LDOLLAR,
        PH_LCOLON,
        PH_PREOP,
        PH_OP,
        PH_PREARG,
        PH_ARG,
        PH_COMMENT,
        PH_DISCARD
    } phase_t;

    // Role of one byte in the line.
    typedef enum logic [3:0] {
        CLS_SPACE,
        CLS_LABEL,
        CLS_COLON,
        CLS_EXPORT,
        CLS_OP,
        CLS_ARG,
        CLS_COMMA,
        CLS_COMMENT,
        CLS_DISCARD,
        CLS_LINE_END
    } tok_class_t;

    // Error held for the rest of a line.
    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_LABEL,
        ERR_OP,
        ERR_LONG,
        ERR_NEST,
        ERR_ARGS
    } line_err_t;

    // Bracket kinds kept on the nesting stack.
    typedef enum logic [1:0] {
        BR_PAREN,
        BR_SQUARE,
        BR_CURLY
    } brk_kind_t;

    typedef struct packed {
        logic      hit;
        brk_kind_t kind;
    } br_match_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_end_mark(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_NUL);
    endfunction

    function automatic br_match_t open_kind(input logic [7:0] c);
        br_match_t m;
        m.hit  = 1'b1;
        m.kind = BR_PAREN;
        if (c == 8'h28)
            m.kind = BR_PAREN;
        else if (c == 8'h5B)
            m.kind = BR_SQUARE;
        else if (c == 8'h7B)
            m.kind = BR_CURLY;
        else
            m.hit = 1'b0;
        return m;
    endfunction

    function automatic br_match_t close_kind(input logic [7:0] c);
        br_match_t m;
        m.hit  = 1'b1;
        m.kind = BR_PAREN;
        if (c == 8'h29)
            m.kind = BR_PAREN;
        else if (c == 8'h5D)
            m.kind = BR_SQUARE;
        else if (c == 8'h7D)
            m.kind = BR_CURLY;
        else
            m.hit = 1'b0;
        return m;
    endfunction

endpackage

@@ hw/rtl/asm_line_tokenizer_top.sv @@
// Assembler line tokenizer: tags each source byte with its role in the line.
//
//  Port group   | Dir | Handshake             | Payload
//  -------------+-----+-----------------------+------------------------------------------
//  source byte  | in  | src_valid / src_ready | ch
//  result       | out | res_valid / res_ready | char_class, arg_index, nest_depth,
//               |     |                       | error_code, line_last
//
// One byte is taken per cycle while the result side keeps up; each byte passes the input
// register, then the classification logic into the result register.
// The per-byte state update is a single combinational pass, so throughput is
// one byte per clock whenever the result side keeps up.
// Reset clears the line state; the bracket stack memory holds no reset value.
// A stalled result holds both stages; src_ready stays high while the input
// register is empty or moving on.
module asm_line_tokenizer_top
#(
    parameter int LINE_LIMIT = alt_pkg::LINE_LIMIT_DEF,
    parameter int NEST_LIMIT = alt_pkg::NEST_LIMIT_DEF,
    parameter int ARG_LIMIT  = alt_pkg::ARG_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_ready,
    input  logic [7:0] ch,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [3:0] char_class,
    output logic [5:0] arg_index,
    output logic [4:0] nest_depth,
    output logic [2:0] error_code,
    output logic       line_last
);
    import alt_pkg::*;

    localparam int CW = $clog2(LINE_LIMIT + 1);
    localparam int DW = $clog2(NEST_LIMIT + 1);
    localparam int SW = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;
    localparam int AW = $clog2(ARG_LIMIT + 1);

    // Input stage.
    logic       in_valid_reg;
    logic [7:0] ch_reg;

    // Line state.
    phase_t    phase_reg,      phase_next;
    logic [CW-1:0] column_reg, column_next;
    logic [AW-1:0] arg_count_reg, arg_count_next;
    logic [DW-1:0] depth_reg,  depth_next;
    line_err_t line_error_reg, line_error_next;
    brk_kind_t top_reg;
    brk_kind_t stack_mem [NEST_LIMIT];

    // Result stage.
    logic       res_valid_reg;
    tok_class_t cls_reg,    cls_next;
    logic [5:0] aidx_reg,   aidx_next;
    logic [4:0] ndepth_reg, ndepth_next;
    line_err_t  err_reg,    err_next;
    logic       last_reg,   last_next;

    logic      adv;
    logic      push;
    brk_kind_t push_kind;
    logic [SW-1:0] rd_addr;

    // Handshake: the input register moves on when the result register is free.
    assign adv       = in_valid_reg && (!res_valid_reg || res_ready);
    assign src_ready = !in_valid_reg || adv;

    // Classification of the byte in the input register.
    always_comb
    begin
        logic       fail_en;
        line_err_t  fail_code;
        logic       cmt_en;
        logic       op_en;
        logic       arg_en;
        br_match_t  om;
        br_match_t  cm;

        phase_next      = phase_reg;
        column_next     = column_reg;
        arg_count_next  = arg_count_reg;
        depth_next      = depth_reg;
        line_error_next = line_error_reg;
        cls_next        = CLS_SPACE;
        aidx_next       = '0;
        err_next        = line_error_reg;
        last_next       = 1'b0;
        push            = 1'b0;
        push_kind       = BR_PAREN;
        fail_en         = 1'b0;
        fail_code       = ERR_NONE;
        cmt_en          = 1'b0;
        op_en           = 1'b0;
        arg_en          = 1'b0;
        om              = open_kind(ch_reg);
        cm              = close_kind(ch_reg);

        if (ch_reg == CH_NEWLINE)
        begin
            // Line end: report and clear the line state.
            cls_next = CLS_LINE_END;
            if (phase_reg == PH_LDIGIT && line_error_reg == ERR_NONE)
                err_next = ERR_LABEL;
            aidx_next       = (arg_count_reg != '0) ? 6'(arg_count_reg - 1'b1) : 6'd0;
            last_next       = 1'b1;
            phase_next      = PH_START;
            column_next     = '0;
            arg_count_next  = '0;
            depth_next      = '0;
            line_error_next = ERR_NONE;
        end
        else
        begin
            if (phase_reg != PH_DISCARD && column_reg >= CW'(LINE_LIMIT - 1))
            begin
                fail_en   = 1'b1;
                fail_code = ERR_LONG;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        priority if (is_ws(ch_reg))
                        begin
                            phase_next = PH_PREOP;
                            cls_next   = CLS_SPACE;
                        end
                        else if (is_end_mark(ch_reg))
                            cmt_en = 1'b1;
                        else if (ch_reg == CH_DOT || ch_reg == CH_UNDER || is_alpha(ch_reg))
                        begin
                            phase_next = PH_LABEL;
                            cls_next   = CLS_LABEL;
                        end
                        else if (is_digit(ch_reg))
                        begin
                            phase_next = PH_LDIGIT;
                            cls_next   = CLS_LABEL;
                        end
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LABEL;
                        end
                    end
                    PH_LABEL:
                    begin
                        priority if (is_word(ch_reg))
                            cls_next = CLS_LABEL;
                        else if (ch_reg == CH_COLON)
                        begin
                            phase_next = PH_LCOLON;
                            cls_next   = CLS_COLON;
                        end
                        else if (is_ws(ch_reg))
                        begin
                            phase_next = PH_PREOP;
                            cls_next   = CLS_SPACE;
                        end
                        else if (is_end_mark(ch_reg))
                            cmt_en = 1'b1;
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LABEL;
                        end
                    end
                    PH_LDIGIT:
                    begin
                        if (ch_reg == CH_DOLLAR)
                        begin
                            phase_next = PH_LDOLLAR;
                            cls_next   = CLS_LABEL;
                        end
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LABEL;
                        end
                    end
                    PH_LDOLLAR:
                    begin
                        priority if (is_ws(ch_reg))
                        begin
                            phase_next = PH_PREOP;
                            cls_next   = CLS_SPACE;
                        end
                        else if (is_end_mark(ch_reg))
                            cmt_en = 1'b1;
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LABEL;
                        end
                    end
                    PH_LCOLON:
                    begin
                        if (ch_reg == CH_COLON)
                        begin
                            phase_next = PH_PREOP;
                            cls_next   = CLS_EXPORT;
                        end
                        else
                            op_en = 1'b1;
                    end
                    PH_PREOP:
                        op_en = 1'b1;
                    PH_OP:
                    begin
                        priority if (is_word(ch_reg))
                            cls_next = CLS_OP;
                        else if (is_ws(ch_reg))
                        begin
                            phase_next = PH_PREARG;
                            cls_next   = CLS_SPACE;
                        end
                        else if (is_end_mark(ch_reg))
                            cmt_en = 1'b1;
                        else
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_OP;
                        end
                    end
                    PH_PREARG:
                    begin
                        priority if (is_ws(ch_reg))
                            cls_next = CLS_SPACE;
                        else if (is_end_mark(ch_reg))
                            cmt_en = 1'b1;
                        else if (arg_count_reg >= AW'(ARG_LIMIT))
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_ARGS;
                        end
                        else
                        begin
                            arg_count_next = arg_count_reg + 1'b1;
                            phase_next     = PH_ARG;
                            arg_en         = 1'b1;
                        end
                    end
                    PH_ARG:
                        arg_en = 1'b1;
                    PH_COMMENT:
                        cls_next = CLS_COMMENT;
                    PH_DISCARD:
                        cls_next = CLS_DISCARD;
                    default:
                    begin
                        phase_next = PH_DISCARD;
                        cls_next   = CLS_DISCARD;
                    end
                endcase
            end

            // Where an operation name may start.
            if (op_en)
            begin
                priority if (is_ws(ch_reg))
                begin
                    phase_next = PH_PREOP;
                    cls_next   = CLS_SPACE;
                end
                else if (is_end_mark(ch_reg))
                    cmt_en = 1'b1;
                else if (ch_reg == CH_UNDER || is_alpha(ch_reg))
                begin
                    phase_next = PH_OP;
                    cls_next   = CLS_OP;
                end
                else
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_OP;
                end
            end

            // Byte inside an argument, with bracket tracking.
            if (arg_en)
            begin
                if (is_end_mark(ch_reg))
                    cmt_en = 1'b1;
                else
                begin
                    aidx_next = 6'(arg_count_next - 1'b1);
                    priority if (ch_reg == CH_COMMA && depth_reg == '0)
                    begin
                        phase_next = PH_PREARG;
                        cls_next   = CLS_COMMA;
                    end
                    else if (is_ws(ch_reg))
                        cls_next = CLS_SPACE;
                    else if (om.hit)
                    begin
                        if (depth_reg >= DW'(NEST_LIMIT))
                        begin
                            aidx_next = '0;
                            fail_en   = 1'b1;
                            fail_code = ERR_NEST;
                        end
                        else
                        begin
                            push       = 1'b1;
                            push_kind  = om.kind;
                            depth_next = depth_reg + 1'b1;
                            cls_next   = CLS_ARG;
                        end
                    end
                    else
                    begin
                        // A close bracket that does not match the top is plain text.
                        if (cm.hit && depth_reg != '0 && top_reg == cm.kind)
                            depth_next = depth_reg - 1'b1;
                        cls_next = CLS_ARG;
                    end
                end
            end

            if (cmt_en)
            begin
                phase_next = PH_COMMENT;
                depth_next = '0;
                cls_next   = CLS_COMMENT;
            end

            if (fail_en)
            begin
                line_error_next = fail_code;
                phase_next      = PH_DISCARD;
                depth_next      = '0;
                cls_next        = CLS_DISCARD;
            end

            if (column_reg < CW'(LINE_LIMIT))
                column_next = column_reg + 1'b1;
            err_next = line_error_next;
        end

        ndepth_next = 5'(depth_next);
    end

    // Next top of stack is read at the new depth; a push bypasses the memory.
    assign rd_addr = SW'(depth_next - 1'b1);

    // Bracket stack memory and registered top read.
    always_ff @(posedge clk)
    begin
        if (adv && push)
            stack_mem[SW'(depth_reg)] <= push_kind;
        if (adv)
            top_reg <= push ? push_kind : stack_mem[rd_addr];
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_ready)
            in_valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
            ch_reg <= ch;
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            column_reg     <= '0;
            arg_count_reg  <= '0;
            depth_reg      <= '0;
            line_error_reg <= ERR_NONE;
        end
        else if (adv)
        begin
            phase_reg      <= phase_next;
            column_reg     <= column_next;
            arg_count_reg  <= arg_count_next;
            depth_reg      <= depth_next;
            line_error_reg <= line_error_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg    <= cls_next;
            aidx_reg   <= aidx_next;
            ndepth_reg <= ndepth_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign char_class = cls_reg;
    assign arg_index  = aidx_reg;
    assign nest_depth = ndepth_reg;
    assign error_code = err_reg;
    assign line_last  = last_reg;

    // Brackets are only open while inside an argument.
    a_depth_in_arg: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg != '0) |-> (phase_reg == PH_ARG))
        else $error("bracket depth nonzero outside an argument");

    // Discarding always carries an error.
    a_discard_err: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DISCARD) |-> (line_error_reg != ERR_NONE))
        else $error("discard phase without a line error");

    // Depth never exceeds the nesting limit.
    a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(NEST_LIMIT))
        else $error("bracket depth over limit");

    // A line end result is tagged as such and leaves no open brackets.
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && last_reg) |-> (cls_reg == CLS_LINE_END && ndepth_reg == 5'd0))
        else $error("line end result malformed");

    // Before the line end, an error only shows on discarded bytes.
    a_err_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !last_reg && err_reg != ERR_NONE) |-> (cls_reg == CLS_DISCARD))
        else $error("error reported on a byte that was not discarded");

    // A line end clears the line state.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ch_reg == CH_NEWLINE) |=> (column_reg == '0 && phase_reg == PH_START))
        else $error("line state not cleared at line end");

endmodule
